>>> hw/rtl/modexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
package modexp_pkg;

  localparam int MOD_W  = 31;  // modulus register width
  localparam int BASE_W = 31;  // base field width
  localparam int EXP_W  = 32;  // exponent field width
  localparam int RES_W  = 32;  // result field width

  localparam logic OP_POW = 1'b0;
  localparam logic OP_LEG = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_BIT,
    S_MUL,
    S_SQR
  } modexp_state_t;

endpackage

>>> hw/rtl/modexp_mul.sv
// Bit-serial interleaved modular multiplier, MSB of a first, one bit per cycle.
module modexp_mul #(
  parameter int MOD_BITS = modexp_pkg::MOD_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [modexp_pkg::BASE_W-1:0] a,
  input  logic [MOD_BITS-1:0]           b,
  input  logic [MOD_BITS-1:0]           m,
  output logic                          done,
  output logic [MOD_BITS-1:0]           p
);
  import modexp_pkg::*;

  localparam int CNT_W = $clog2(BASE_W + 1);
  localparam int SUM_W = MOD_BITS + 2;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BASE_W-1:0] a_r, a_nxt;
  logic [MOD_BITS-1:0] b_r, b_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] m1;
  logic [SUM_W-1:0] m2;
  logic [SUM_W-1:0] red;

  // 2*acc + bit*b stays below 3m: subtract 2m or m as needed
  assign m1  = {2'b00, m};
  assign m2  = {1'b0, m, 1'b0};
  assign sum = {1'b0, acc_r, 1'b0} + (a_r[BASE_W-1] ? {2'b00, b_r} : '0);

  always_comb begin
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(BASE_W);
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      a_nxt   = {a_r[BASE_W-2:0], 1'b0};
      acc_nxt = red[MOD_BITS-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

>>> hw/rtl/modular_exponentiation.sv
// Top level: modular power and Legendre symbol by square-and-multiply.
//
// Each input beat carries op, base and exponent; one result beat comes back.
// op 0 gives base^exponent mod modulus (1 for exponent 0); op 1 raises base
// to (modulus-1)/2 and returns -1 (all ones) when that residue is modulus-1,
// the residue otherwise. A modulus of 0 or 1 yields 0. The modulus is a
// config register (reset 2) written through cfg_we/cfg_modulus. The user
// must write it only while the block is idle; the block itself does not
// enforce this. Only its low MOD_BITS bits are kept. One item at a time:
// every modular product runs on a single bit-serial multiplier, first to
// reduce the base (base*1), then for each of the EXP_BITS exponent bits a
// square plus a multiply when the bit is set, with a decision state per
// bit. The result sits in an output register, so the next item is taken
// while an earlier result waits for out_ready.
module modular_exponentiation #(
  parameter int MOD_BITS = modexp_pkg::MOD_W,
  parameter int EXP_BITS = modexp_pkg::EXP_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config
  input  logic                                cfg_we,
  input  logic [modexp_pkg::MOD_W-1:0]        cfg_modulus,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [modexp_pkg::BASE_W-1:0]       in_base,
  input  logic [modexp_pkg::EXP_W-1:0]        in_exponent,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [modexp_pkg::RES_W-1:0] out_result
);
  import modexp_pkg::*;

  localparam int ECNT_W = $clog2(EXP_BITS + 1);

  modexp_state_t state_r, state_nxt;

  logic [MOD_BITS-1:0] mod_r;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;    // running product
  logic [MOD_BITS-1:0] sq_r, sq_nxt;      // running square of the base
  logic [EXP_BITS-1:0] e_r, e_nxt;        // exponent, shifted right per bit
  logic [ECNT_W-1:0]   ecnt_r, ecnt_nxt;  // exponent bits left
  logic                op_r, op_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]    out_result_r, out_result_nxt;

  // multiplier hookup
  logic                mul_start;
  logic [BASE_W-1:0]   mul_a;
  logic [MOD_BITS-1:0] mul_b;
  logic                mul_done;
  logic [MOD_BITS-1:0] mul_p;

  logic                in_beat;
  logic                out_free;
  logic                mod_small;
  logic [MOD_BITS-1:0] mod_m1;
  logic [EXP_BITS+MOD_BITS-1:0] leg_wide;
  logic [EXP_BITS-1:0] leg_exp;

  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign mod_small = mod_r < MOD_BITS'(2);
  assign mod_m1    = mod_r - MOD_BITS'(1);
  // Legendre exponent (m-1)/2, cut to the scanned exponent width
  assign leg_wide  = {{EXP_BITS{1'b0}}, mod_m1} >> 1;
  assign leg_exp   = leg_wide[EXP_BITS-1:0];

  modexp_mul #(
    .MOD_BITS(MOD_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (mod_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    sq_nxt         = sq_r;
    e_nxt          = e_r;
    ecnt_nxt       = ecnt_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    mul_start      = 1'b0;
    mul_a          = BASE_W'(sq_r);
    mul_b          = sq_r;
    in_ready       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mod_small) begin
            // nothing to reduce against: result is 0
            acc_nxt   = '0;
            ecnt_nxt  = '0;
            op_nxt    = OP_POW;
            state_nxt = S_BIT;
          end else begin
            op_nxt    = in_op;
            e_nxt     = (in_op == OP_LEG) ? leg_exp : in_exponent[EXP_BITS-1:0];
            ecnt_nxt  = ECNT_W'(EXP_BITS);
            acc_nxt   = MOD_BITS'(1);
            // reduce the base as base * 1
            mul_start = 1'b1;
            mul_a     = in_base;
            mul_b     = MOD_BITS'(1);
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (mul_done) begin
          sq_nxt    = mul_p;
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        if (ecnt_r == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            if (op_r == OP_LEG && acc_r == mod_m1) begin
              out_result_nxt = '1;
            end else begin
              out_result_nxt = RES_W'(acc_r);
            end
            state_nxt = S_IDLE;
          end
        end else if (e_r[0]) begin
          mul_start = 1'b1;
          mul_a     = BASE_W'(acc_r);
          state_nxt = S_MUL;
        end else begin
          mul_start = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          acc_nxt   = mul_p;
          mul_start = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (mul_done) begin
          sq_nxt    = mul_p;
          e_nxt     = e_r >> 1;
          ecnt_nxt  = ecnt_r - ECNT_W'(1);
          state_nxt = S_BIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_BITS'(2);
      ecnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ecnt_r      <= ecnt_nxt;
      if (cfg_we) begin
        mod_r <= cfg_modulus[MOD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    sq_r         <= sq_nxt;
    e_r          <= e_nxt;
    op_r         <= op_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

`ifndef SYNTH
  // the multiplier only finishes while the sequencer waits on it
  a_mul_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_RED || state_r == S_MUL || state_r == S_SQR))
    else $error("multiplier done outside a wait state");

  // an accepted beat always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");

  // a result appears only from the decision state
  a_result_from_bit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_BIT))
    else $error("result raised outside the decision state");
`endif

endmodule
